// ===== rtl/adam_parameter_update_defines.svh =====
// ----------------------------------------------------------------------------
// Adam parameter update: assertion macros
// Shared property wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ADAM_PARAMETER_UPDATE_DEFINES_SVH
`define ADAM_PARAMETER_UPDATE_DEFINES_SVH

// Same-cycle implication.
`define ADAMU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ADAMU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/adamu_pkg.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update: shared package
// Widths, reset values, state and command types shared by all modules.
// ----------------------------------------------------------------------------
package adamu_pkg;

  localparam int unsigned FracBits     = 24;
  localparam int unsigned IdxWidth     = 10;
  localparam int unsigned DataWidth    = 32;
  localparam int unsigned BetaWidth    = 24;
  localparam int unsigned EpsWidth     = 24;
  localparam int unsigned RateInWidth  = 31;
  localparam int unsigned PowWidth     = 25;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 31;
  localparam int unsigned DefaultDepth = 1024;

  // Root of a radicand below 2^56.
  localparam int unsigned SqrtRootWidth = 28;
  localparam int unsigned SqrtRadWidth  = 2 * SqrtRootWidth;

  // Restoring divider: 34-bit quotient, 29-bit divisor.
  localparam int unsigned DivQuoWidth = 34;
  localparam int unsigned DivDenWidth = 29;
  localparam int unsigned DivNumWidth = DivQuoWidth + DivDenWidth + 1;

  localparam logic [PowWidth-1:0] OneQ24 = 25'h100_0000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_BETA_ONE  = 2'd0,
    CFG_BETA_TWO  = 2'd1,
    CFG_EPSILON   = 2'd2,
    CFG_BASE_RATE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [BetaWidth-1:0]   beta_one;
    logic [BetaWidth-1:0]   beta_two;
    logic [EpsWidth-1:0]    epsilon_term;
    logic [RateInWidth-1:0] base_rate;
  } adamu_cfg_t;

  localparam adamu_cfg_t CfgReset = '{
    beta_one:     24'd15099494,
    beta_two:     24'd16760439,
    epsilon_term: 24'd1,
    base_rate:    31'd167772
  };

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_POW,
    ST_RSQ_GO,
    ST_RSQ_WAIT,
    ST_RMUL,
    ST_RDIV_GO,
    ST_RDIV_WAIT,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_VSQ_GO,
    ST_VSQ_WAIT,
    ST_VDIV_GO,
    ST_VDIV_WAIT,
    ST_FIN
  } adamu_state_e;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic mod_step;
    logic pow_update;
    logic sqrt_start;
    logic div_start;
    logic sel_item;
    logic rate_mul;
    logic rate_latch;
    logic mem_read;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mom_write;
    logic out_load;
  } adamu_cmd_t;

  typedef struct packed {
    logic first;
    logic clear_last;
    logic sqrt_busy;
    logic div_busy;
  } adamu_sts_t;

endpackage

// ===== rtl/adam_parameter_update.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update: top level
// Adam optimizer step in Q8.24 fixed point with stored moments per element.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) transfers one parameter, its
//   gradient, an element index and a first-of-pass mark. Output channel
//   (out_valid_o / out_stall_i) transfers the index, the updated parameter
//   and a saturation flag. Configuration writes go through cfg_valid_i /
//   cfg_ready_o with a register index; ready is always high.
//   One item at a time: the block takes the next item only once the result
//   of the last one is loaded into the output register. A first-of-pass
//   item adds a bias correction step. The work is done by the bit-serial
//   square root (one root bit per cycle), the restoring divider (one quotient
//   bit per cycle) and an index reduction, all run one after another.
//   After reset the moment memories are swept to zero, one entry per cycle,
//   over all VECTOR_DEPTH entries; the input stalls during the sweep.
//   A stalled result holds in the output register while the next item is
//   taken and worked on; that item waits at its last step until the
//   register drains.
// ----------------------------------------------------------------------------
`include "adam_parameter_update_defines.svh"

module adam_parameter_update #(
  parameter int unsigned VECTOR_DEPTH = adamu_pkg::DefaultDepth
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // input channel
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic [adamu_pkg::IdxWidth-1:0]            elem_index_i,
  input  logic                                      first_of_pass_i,
  input  logic signed [adamu_pkg::DataWidth-1:0]    param_value_i,
  input  logic signed [adamu_pkg::DataWidth-1:0]    grad_value_i,
  // output channel
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [adamu_pkg::IdxWidth-1:0]            out_index_o,
  output logic signed [adamu_pkg::DataWidth-1:0]    new_value_o,
  output logic                                      saturated_o,
  // configuration write channel
  input  logic                                      cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  logic [adamu_pkg::CfgIdxWidth-1:0]         cfg_index_i,
  input  logic [adamu_pkg::CfgDataWidth-1:0]        cfg_data_i
);

  adamu_pkg::adamu_cfg_t cfg_q, cfg_d;
  adamu_pkg::adamu_cmd_t cmd;
  adamu_pkg::adamu_sts_t sts;

  // Configuration registers: take a write on every transfer, keep low bits.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        adamu_pkg::CFG_BETA_ONE:  cfg_d.beta_one     = cfg_data_i[adamu_pkg::BetaWidth-1:0];
        adamu_pkg::CFG_BETA_TWO:  cfg_d.beta_two     = cfg_data_i[adamu_pkg::BetaWidth-1:0];
        adamu_pkg::CFG_EPSILON:   cfg_d.epsilon_term = cfg_data_i[adamu_pkg::EpsWidth-1:0];
        adamu_pkg::CFG_BASE_RATE: cfg_d.base_rate    = cfg_data_i[adamu_pkg::RateInWidth-1:0];
        default:                  cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= adamu_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Sequencer: clear sweep, pass start, moment update, result handoff.
  adamu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic, moment memories and the output register.
  adamu_dp #(
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_i           (cfg_q),
    .elem_index_i    (elem_index_i),
    .first_of_pass_i (first_of_pass_i),
    .param_value_i   (param_value_i),
    .grad_value_i    (grad_value_i),
    .out_index_o     (out_index_o),
    .new_value_o     (new_value_o),
    .saturated_o     (saturated_o)
  );

  // One item in flight: after a transfer the input stalls.
  `ADAMU_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o, "second item taken while busy")
  // Never overwrite a result that is still held by the receiver.
  `ADAMU_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_o || !out_stall_i, "result overwritten")
  // Shared units are started only when idle.
  `ADAMU_ASSERT_NOW(a_sqrt_idle, cmd.sqrt_start, !sts.sqrt_busy, "root unit restarted while busy")
  `ADAMU_ASSERT_NOW(a_div_idle, cmd.div_start, !sts.div_busy, "divider restarted while busy")

endmodule

// ===== rtl/adamu_sqrt.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update: integer square root
// Digit-by-digit floor root, one result bit per cycle.
// ----------------------------------------------------------------------------
module adamu_sqrt (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [adamu_pkg::SqrtRadWidth-1:0]   rad_i,
  output logic                                 busy_o,
  output logic [adamu_pkg::SqrtRootWidth-1:0]  root_o
);

  localparam int unsigned RW  = adamu_pkg::SqrtRootWidth;
  localparam int unsigned RW1 = RW + 1;
  localparam int unsigned CW  = $clog2(RW);

  // The partial remainder can reach twice the partial root: one bit more.
  logic [2*RW-1:0] rad_q;
  logic [RW:0]     rem_q;
  logic [RW-1:0]   root_q;
  logic [RW+2:0]   rem_t;
  logic [RW+2:0]   trial;
  logic            take;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;

  assign rem_t = {rem_q, rad_q[2*RW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign take  = (rem_t >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(RW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*RW-3:0], 2'b00};
      rem_q  <= take ? RW1'(rem_t - trial) : rem_t[RW:0];
      root_q <= {root_q[RW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== rtl/adamu_div.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update: restoring divider
// One quotient bit per cycle, with an up-front quotient overflow check.
// ----------------------------------------------------------------------------
module adamu_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [adamu_pkg::DivNumWidth-1:0]  num_i,
  input  logic [adamu_pkg::DivDenWidth-1:0]  den_i,
  output logic                               busy_o,
  output logic                               ovf_o,
  output logic [adamu_pkg::DivQuoWidth-1:0]  quo_o
);

  localparam int unsigned QW = adamu_pkg::DivQuoWidth;
  localparam int unsigned DW = adamu_pkg::DivDenWidth;
  localparam int unsigned NW = adamu_pkg::DivNumWidth;
  localparam int unsigned CW = $clog2(QW);

  logic [QW-1:0] num_q;
  logic [QW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic          ovf_q;
  logic [DW:0]   t;
  logic          take;
  logic [CW-1:0] cnt_q;
  logic          busy_q;

  assign t    = {rem_q, num_q[QW-1]};
  assign take = (t >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(QW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // High part at or above the divisor means the quotient does not fit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= (num_i[NW-1:QW] >= {1'b0, den_i});
      rem_q <= num_i[NW-2:QW];
      num_q <= num_i[QW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? DW'(t - {1'b0, den_q}) : t[DW-1:0];
      num_q <= {num_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/adamu_dp.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update: datapath
// Item registers, moment memories, bias powers, products and result register.
// ----------------------------------------------------------------------------
module adamu_dp #(
  parameter int unsigned VECTOR_DEPTH = adamu_pkg::DefaultDepth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  adamu_pkg::adamu_cmd_t                  cmd_i,
  output adamu_pkg::adamu_sts_t                  sts_o,
  input  adamu_pkg::adamu_cfg_t                  cfg_i,
  input  logic [adamu_pkg::IdxWidth-1:0]         elem_index_i,
  input  logic                                   first_of_pass_i,
  input  logic signed [adamu_pkg::DataWidth-1:0] param_value_i,
  input  logic signed [adamu_pkg::DataWidth-1:0] grad_value_i,
  output logic [adamu_pkg::IdxWidth-1:0]         out_index_o,
  output logic signed [adamu_pkg::DataWidth-1:0] new_value_o,
  output logic                                   saturated_o
);

  localparam int unsigned AW  = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(VECTOR_DEPTH - 1);
  localparam int unsigned IW  = adamu_pkg::IdxWidth;
  localparam int unsigned PW  = adamu_pkg::PowWidth;
  localparam int unsigned QW  = adamu_pkg::DivQuoWidth;
  localparam int unsigned DNW = adamu_pkg::DivDenWidth;
  localparam int unsigned RTW = adamu_pkg::SqrtRootWidth;
  localparam int unsigned ModShift = 2 * IW + 1;
  localparam logic [31:0] ModRecip =
    32'(((64'd1 << ModShift) + 64'(VECTOR_DEPTH) - 64'd1) / 64'(VECTOR_DEPTH));
  localparam logic [31:0] DepthWord = 32'(VECTOR_DEPTH);

  // Item registers
  logic [IW-1:0] idx_q;
  logic          first_q;
  logic [31:0]   param_q;
  logic [31:0]   grad_q;

  // Index reduction
  logic [AW-1:0] slot_q;
  logic [31:0]   mod_prod;
  logic [31:0]   mod_quo;
  logic [31:0]   mod_rem;

  // Pass state
  logic [PW-1:0] p1_q, p2_q;
  logic [31:0]   rate_q;
  logic [48:0]   p1_prod, p2_prod;
  logic [PW-1:0] d1, d2;

  // Moment memories and clear sweep
  logic [31:0]   m_mem [VECTOR_DEPTH];
  logic [30:0]   v_mem [VECTOR_DEPTH];
  logic [AW-1:0] clr_q;
  logic [31:0]   m_rd_q;
  logic [30:0]   v_rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   m_wdata;
  logic [30:0]   v_wdata;

  // Moment arithmetic
  logic [PW-1:0]        c1, c2;
  logic [31:0]          g_abs, m_abs;
  logic [63:0]          gg;
  logic signed [56:0]   mt1_q;
  logic signed [57:0]   mt2_q;
  logic [38:0]          gsq_q;
  logic signed [58:0]   m_sum;
  logic [34:0]          m_fl;
  logic [31:0]          m_q;
  logic                 m_sat_q;
  logic [54:0]          vt1_q;
  logic [44:0]          vt2lo_q;
  logic [43:0]          vt2hi_q;
  logic [63:0]          v_sum;
  logic [39:0]          v_fl;
  logic [30:0]          v_q;
  logic                 v_sat_q;

  // Shared units
  logic [adamu_pkg::SqrtRadWidth-1:0] sqrt_rad;
  logic                               sqrt_busy;
  logic [RTW-1:0]                     sqrt_root;
  logic [adamu_pkg::DivNumWidth-1:0]  num_q;
  logic [DNW-1:0]                     div_den;
  logic [DNW-1:0]                     den_sum;
  logic [DNW-1:0]                     den_item;
  logic                               div_busy;
  logic                               div_ovf;
  logic [QW-1:0]                      div_quo;
  logic [58:0]                        rate_prod;
  logic [63:0]                        step_prod;

  // Result
  logic [QW-1:0]        mag;
  logic signed [35:0]   res;
  logic                 res_sat;
  logic [31:0]          res_clamped;
  logic [IW-1:0]        out_index_q;
  logic [31:0]          new_value_q;
  logic                 sat_q;

  // ---------------- capture and index reduction ----------------
  // Reciprocal multiply: the quotient is exact for every index below 2^IW.
  assign mod_prod = {{(32-IW){1'b0}}, idx_q} * ModRecip;
  assign mod_quo  = mod_prod >> ModShift;
  assign mod_rem  = {{(32-IW){1'b0}}, idx_q} - mod_quo * DepthWord;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      idx_q    <= elem_index_i;
      first_q  <= first_of_pass_i;
      param_q  <= param_value_i;
      grad_q   <= grad_value_i;
    end
    if (cmd_i.mod_step) begin
      slot_q <= mod_rem[AW-1:0];
    end
  end

  // ---------------- bias powers and corrected rate ----------------
  assign p1_prod = p1_q * cfg_i.beta_one;
  assign p2_prod = p2_q * cfg_i.beta_two;
  assign d1      = adamu_pkg::OneQ24 - p1_q;
  assign d2      = adamu_pkg::OneQ24 - p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q   <= adamu_pkg::OneQ24;
      p2_q   <= adamu_pkg::OneQ24;
      rate_q <= '0;
    end else begin
      if (cmd_i.pow_update) begin
        p1_q <= p1_prod[48:24];
        p2_q <= p2_prod[48:24];
      end
      if (cmd_i.rate_latch) begin
        if (d1 == '0) begin
          rate_q <= '0;
        end else if (div_ovf || (div_quo[QW-1:32] != '0)) begin
          rate_q <= '1;
        end else begin
          rate_q <= div_quo[31:0];
        end
      end
    end
  end

  // ---------------- moment memories ----------------
  assign mem_we    = cmd_i.clear_wr | cmd_i.mom_write;
  assign mem_waddr = cmd_i.clear_wr ? clr_q : slot_q;
  assign m_wdata   = cmd_i.clear_wr ? '0 : m_q;
  assign v_wdata   = cmd_i.clear_wr ? '0 : v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      m_mem[mem_waddr] <= m_wdata;
      v_mem[mem_waddr] <= v_wdata;
    end
    if (cmd_i.mem_read) begin
      m_rd_q <= m_mem[slot_q];
      v_rd_q <= v_mem[slot_q];
    end
  end

  // ---------------- moment update ----------------
  assign c1    = adamu_pkg::OneQ24 - {1'b0, cfg_i.beta_one};
  assign c2    = adamu_pkg::OneQ24 - {1'b0, cfg_i.beta_two};
  assign g_abs = grad_q[31] ? (~grad_q + 32'd1) : grad_q;
  assign gg    = g_abs * g_abs;
  assign m_sum = mt1_q + mt2_q;
  assign m_fl  = m_sum[58:24];
  assign v_sum = 64'(vt1_q) + 64'(vt2lo_q) + {vt2hi_q, 20'b0};
  assign v_fl  = v_sum[63:24];
  assign m_abs = m_q[31] ? (~m_q + 32'd1) : m_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      mt1_q <= $signed({1'b0, cfg_i.beta_one}) * $signed(m_rd_q);
      mt2_q <= $signed({1'b0, c1}) * $signed(grad_q);
      gsq_q <= gg[62:24];
    end
    if (cmd_i.mul2) begin
      // Floor of a signed value: the upper bits of the sum.
      if ((&m_fl[34:31]) || !(|m_fl[34:31])) begin
        m_q     <= m_fl[31:0];
        m_sat_q <= 1'b0;
      end else begin
        m_q     <= m_fl[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        m_sat_q <= 1'b1;
      end
      vt1_q   <= cfg_i.beta_two * v_rd_q;
      vt2lo_q <= c2 * gsq_q[19:0];
      vt2hi_q <= c2 * gsq_q[38:20];
    end
    if (cmd_i.mul3) begin
      if (v_fl[39:31] != '0) begin
        v_q     <= 31'h7FFF_FFFF;
        v_sat_q <= 1'b1;
      end else begin
        v_q     <= v_fl[30:0];
        v_sat_q <= 1'b0;
      end
    end
  end

  // ---------------- root and divide operands ----------------
  assign sqrt_rad  = cmd_i.sel_item ? {1'b0, v_q, 24'b0} : {7'b0, d2, 24'b0};
  assign den_sum   = {1'b0, sqrt_root} + {5'b0, cfg_i.epsilon_term};
  assign den_item  = (den_sum == '0) ? DNW'(1) : den_sum;
  assign div_den   = cmd_i.sel_item ? den_item : {4'b0, d1};
  assign rate_prod = cfg_i.base_rate * sqrt_root;
  assign step_prod = rate_q * m_abs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rate_mul) begin
      num_q <= {5'b0, rate_prod};
    end else if (cmd_i.mom_write) begin
      num_q <= step_prod;
    end
  end

  adamu_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (sqrt_rad),
    .busy_o  (sqrt_busy),
    .root_o  (sqrt_root)
  );

  adamu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .ovf_o   (div_ovf),
    .quo_o   (div_quo)
  );

  // ---------------- result ----------------
  // Any step of 2^32 or more saturates, so cap the magnitude at 2^33.
  assign mag = (div_ovf || (div_quo > 34'h2_0000_0000)) ? 34'h2_0000_0000 : div_quo;
  assign res = m_q[31] ? ($signed({{4{param_q[31]}}, param_q}) + $signed({2'b0, mag}))
                       : ($signed({{4{param_q[31]}}, param_q}) - $signed({2'b0, mag}));
  assign res_sat     = !((&res[35:31]) || !(|res[35:31]));
  assign res_clamped = res_sat ? (res[35] ? 32'h8000_0000 : 32'h7FFF_FFFF) : res[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= idx_q;
      new_value_q <= res_clamped;
      sat_q       <= m_sat_q | v_sat_q | res_sat;
    end
  end

  assign out_index_o = out_index_q;
  assign new_value_o = new_value_q;
  assign saturated_o = sat_q;

  assign sts_o.first      = first_q;
  assign sts_o.clear_last = (clr_q == LastAddr);
  assign sts_o.sqrt_busy  = sqrt_busy;
  assign sts_o.div_busy   = div_busy;

endmodule

// ===== rtl/adamu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update: controller
// Sequences the clear sweep, pass start, moment update and result handoff.
// ----------------------------------------------------------------------------
module adamu_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  adamu_pkg::adamu_sts_t sts_i,
  output adamu_pkg::adamu_cmd_t cmd_o
);

  adamu_pkg::adamu_state_e state_q, state_d;
  logic                    out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= adamu_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      adamu_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = adamu_pkg::ST_IDLE;
        end
      end
      adamu_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = adamu_pkg::ST_MOD;
        end
      end
      adamu_pkg::ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        state_d        = sts_i.first ? adamu_pkg::ST_POW : adamu_pkg::ST_READ;
      end
      adamu_pkg::ST_POW: begin
        cmd_o.pow_update = 1'b1;
        state_d          = adamu_pkg::ST_RSQ_GO;
      end
      adamu_pkg::ST_RSQ_GO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = adamu_pkg::ST_RSQ_WAIT;
      end
      adamu_pkg::ST_RSQ_WAIT: begin
        if (!sts_i.sqrt_busy) begin
          state_d = adamu_pkg::ST_RMUL;
        end
      end
      adamu_pkg::ST_RMUL: begin
        cmd_o.rate_mul = 1'b1;
        state_d        = adamu_pkg::ST_RDIV_GO;
      end
      adamu_pkg::ST_RDIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = adamu_pkg::ST_RDIV_WAIT;
      end
      adamu_pkg::ST_RDIV_WAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.rate_latch = 1'b1;
          state_d          = adamu_pkg::ST_READ;
        end
      end
      adamu_pkg::ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = adamu_pkg::ST_MUL1;
      end
      adamu_pkg::ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = adamu_pkg::ST_MUL2;
      end
      adamu_pkg::ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = adamu_pkg::ST_MUL3;
      end
      adamu_pkg::ST_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = adamu_pkg::ST_VSQ_GO;
      end
      adamu_pkg::ST_VSQ_GO: begin
        cmd_o.mom_write  = 1'b1;
        cmd_o.sqrt_start = 1'b1;
        cmd_o.sel_item   = 1'b1;
        state_d          = adamu_pkg::ST_VSQ_WAIT;
      end
      adamu_pkg::ST_VSQ_WAIT: begin
        if (!sts_i.sqrt_busy) begin
          state_d = adamu_pkg::ST_VDIV_GO;
        end
      end
      adamu_pkg::ST_VDIV_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.sel_item  = 1'b1;
        state_d         = adamu_pkg::ST_VDIV_WAIT;
      end
      adamu_pkg::ST_VDIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = adamu_pkg::ST_FIN;
        end
      end
      adamu_pkg::ST_FIN: begin
        // Load only once the output register is free or draining.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = adamu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = adamu_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;

endmodule

// ===== tb/adam_parameter_update_test.sv =====
// ----------------------------------------------------------------------------
// Adam parameter update: self-checking testbench
// Drives parameter/gradient transfers through several register settings,
// predicts every update in fixed point and checks each result in order.
// ----------------------------------------------------------------------------
module adam_parameter_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = adamu_pkg::DefaultDepth;
  localparam int unsigned IW         = adamu_pkg::IdxWidth;
  localparam int unsigned DW         = adamu_pkg::DataWidth;
  localparam int unsigned CDW        = adamu_pkg::CfgDataWidth;
  localparam longint      CycleLimit = 1000000;
  localparam int unsigned NumPhases  = 5;
  localparam int unsigned ItemsPhase = 116;

  typedef struct {
    logic [IW-1:0]        index;
    logic signed [DW-1:0] value;
    logic                 sat;
  } update_t;

  // Predictor of the optimizer step plus the queue of pending updates.
  class adam_tracker;
    logic [DW-1:0]                         m_store[Depth];
    logic [DW-1:0]                         v_store[Depth];
    logic [adamu_pkg::PowWidth-1:0]        pow_one, pow_two;
    logic [DW-1:0]                         rate;
    logic [adamu_pkg::BetaWidth-1:0]       b_one, b_two;
    logic [adamu_pkg::EpsWidth-1:0]        eps;
    logic [adamu_pkg::RateInWidth-1:0]     lr;
    update_t                               pending[$];
    int unsigned                           mismatches, checked, sat_seen;

    function new();
      foreach (m_store[i]) begin
        m_store[i] = '0;
        v_store[i] = '0;
      end
      pow_one = adamu_pkg::OneQ24;
      pow_two = adamu_pkg::OneQ24;
      rate    = '0;
      b_one   = adamu_pkg::CfgReset.beta_one;
      b_two   = adamu_pkg::CfgReset.beta_two;
      eps     = adamu_pkg::CfgReset.epsilon_term;
      lr      = adamu_pkg::CfgReset.base_rate;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void write_reg(adamu_pkg::cfg_idx_e idx, logic [CDW-1:0] data);
      case (idx)
        adamu_pkg::CFG_BETA_ONE:  b_one = data[adamu_pkg::BetaWidth-1:0];
        adamu_pkg::CFG_BETA_TWO:  b_two = data[adamu_pkg::BetaWidth-1:0];
        adamu_pkg::CFG_EPSILON:   eps   = data[adamu_pkg::EpsWidth-1:0];
        adamu_pkg::CFG_BASE_RATE: lr    = data[adamu_pkg::RateInWidth-1:0];
        default:                  ;
      endcase
    endfunction

    function void note_input(logic [IW-1:0] idx, logic first,
                             logic signed [DW-1:0] param,
                             logic signed [DW-1:0] grad);
      longint unsigned d1, d2, s, r, gabs, gsq, v_new, den, mabs, mag;
      longint m_old, m_acc, m_new, g, res;
      int unsigned slot;
      update_t u;
      slot = idx % Depth;
      g = longint'(grad);
      u.sat = 1'b0;
      // Advance the bias powers and latch the corrected rate on a pass start.
      if (first) begin
        pow_one = adamu_pkg::PowWidth'((64'(pow_one) * b_one) >> 24);
        pow_two = adamu_pkg::PowWidth'((64'(pow_two) * b_two) >> 24);
        d1 = 64'(adamu_pkg::OneQ24) - pow_one;
        d2 = 64'(adamu_pkg::OneQ24) - pow_two;
        s  = int_sqrt(d2 << 24);
        if (d1 == 0) r = 0;
        else begin
          r = (64'(lr) * s) / d1;
          if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
        end
        rate = r[31:0];
      end
      m_old = longint'($signed(m_store[slot]));
      m_acc = longint'(b_one) * m_old + (longint'(1 << 24) - longint'(b_one)) * g;
      m_new = m_acc >>> 24;
      if (m_new > 64'sd2147483647) begin m_new = 64'sd2147483647; u.sat = 1'b1; end
      if (m_new < -64'sd2147483648) begin m_new = -64'sd2147483648; u.sat = 1'b1; end
      m_store[slot] = m_new[31:0];
      gabs  = (g < 0) ? -g : g;
      gsq   = (gabs * gabs) >> 24;
      v_new = (64'(b_two) * 64'(v_store[slot][30:0])
               + ((64'd1 << 24) - 64'(b_two)) * gsq) >> 24;
      if (v_new > 64'd2147483647) begin v_new = 64'd2147483647; u.sat = 1'b1; end
      v_store[slot] = v_new[31:0];
      den = int_sqrt(v_new << 24) + eps;
      if (den == 0) den = 1;
      mabs = (m_new < 0) ? -m_new : m_new;
      mag  = (64'(rate) * mabs) / den;
      if (mag > (64'd1 << 33)) mag = 64'd1 << 33;
      res = (m_new < 0) ? longint'(param) + longint'(mag) : longint'(param) - longint'(mag);
      if (res > 64'sd2147483647) begin res = 64'sd2147483647; u.sat = 1'b1; end
      if (res < -64'sd2147483648) begin res = -64'sd2147483648; u.sat = 1'b1; end
      u.index = idx;
      u.value = res[31:0];
      pending.push_back(u);
    endfunction

    function void check_result(logic [IW-1:0] idx,
                               logic signed [DW-1:0] value, logic sat);
      update_t u;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: index %0d value %0d", idx, value);
        return;
      end
      u = pending.pop_front();
      if (sat) sat_seen++;
      if (idx !== u.index || value !== u.value || sat !== u.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp idx %0d val %0d sat %0b, got idx %0d val %0d sat %0b",
                   u.index, u.value, u.sat, idx, value, sat);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [IW-1:0]        elem_index_i = '0;
  logic                 first_of_pass_i = 1'b0;
  logic signed [DW-1:0] param_value_i = '0;
  logic signed [DW-1:0] grad_value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [IW-1:0]        out_index_o;
  logic signed [DW-1:0] new_value_o;
  logic                 saturated_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  adamu_pkg::cfg_idx_e  cfg_index_i = adamu_pkg::CFG_BETA_ONE;
  logic [CDW-1:0]       cfg_data_i = '0;

  adam_tracker sb;
  longint      cycle_count = 0;
  bit          quiet = 1'b0;     // suppress idling on both sides
  bit          hold_req = 1'b0;  // ask the receiver for a long hold-off
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;

  always #1 clk_i = ~clk_i;

  adam_parameter_update i_dut (.*);

  // Abort the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[adam_parameter_update] ERROR");
      $finish;
    end
  end

  // Receiver: check each transfer, then decide the stall for the next cycle.
  // A hold-off request keeps stall high long enough to back up the input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result(out_index_o, new_value_o, saturated_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 34);
      end
    end
  end

  // Write one register and mirror it into the predictor; valid stays high
  // so that writes can follow back to back, the caller drops it.
  task automatic write_cfg(adamu_pkg::cfg_idx_e idx, logic [CDW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  // Offer one item after a random gap; hold it until the transfer.
  task automatic send_item(logic [IW-1:0] idx, logic first,
                           logic signed [DW-1:0] param,
                           logic signed [DW-1:0] grad);
    while (!quiet && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    elem_index_i    <= idx;
    first_of_pass_i <= first;
    param_value_i   <= param;
    grad_value_i    <= grad;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(idx, first, param, grad);
    items_sent++;
  endtask

  // Let every pending update drain before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Mix of tiny, moderate, full-range and extreme Q8.24 values.
  function automatic logic signed [DW-1:0] pick_value();
    int unsigned sel;
    logic signed [DW-1:0] v;
    sel = $urandom_range(99);
    if (sel < 15) v = $signed($urandom_range(8191)) - 4096;
    else if (sel < 60) v = $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    else if (sel < 85) v = $urandom;
    else begin
      case ($urandom_range(3))
        0: v = 32'sh7FFF_FFFF;
        1: v = 32'sh8000_0000;
        2: v = 32'sh0100_0000;
        default: v = -32'sh0100_0000;
      endcase
    end
    return v;
  endfunction

  initial begin
    logic [IW-1:0] base;
    int unsigned pass_len, sent;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: updates before any pass start leave the parameter unchanged.
    send_item(10'd0,    1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(10'd1023, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(10'd5,    1'b0, 32'sh0100_0000, 32'sh0000_1000);
    // First pass with extreme gradients and parameters.
    send_item(10'd0,    1'b1, 32'sh0000_0000, 32'sh7FFF_FFFF);
    send_item(10'd1023, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(10'd1,    1'b0, 32'sh8000_0000, 32'sh0000_0001);
    send_item(10'd512,  1'b0, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
    send_item(10'd0,    1'b1, 32'sh5555_5555, 32'shAAAA_AAAA);
    send_item(10'd1023, 1'b0, 32'shAAAA_AAAA, 32'sh5555_5555);
    send_item(10'd341,  1'b0, 32'sh0000_0000, 32'sh0000_0000);
    drain();

    // Saturating rate and zero epsilon: a zero root falls back to one,
    // and out-of-range register bits are dropped.
    write_cfg(adamu_pkg::CFG_BETA_ONE,  31'h7FFF_FFFF);
    write_cfg(adamu_pkg::CFG_BETA_TWO,  31'h7FFF_FFFF);
    write_cfg(adamu_pkg::CFG_EPSILON,   31'h7F00_0000);
    write_cfg(adamu_pkg::CFG_BASE_RATE, 31'h7FFF_FFFF);
    cfg_valid_i <= 1'b0;
    send_item(10'd700, 1'b1, 32'sh0000_0000, 32'sh0000_0000);
    send_item(10'd701, 1'b0, 32'sh0100_0000, 32'sh0000_0800);
    send_item(10'd702, 1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(10'd703, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    drain();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin
          write_cfg(adamu_pkg::CFG_BETA_ONE,  CDW'(adamu_pkg::CfgReset.beta_one));
          write_cfg(adamu_pkg::CFG_BETA_TWO,  CDW'(adamu_pkg::CfgReset.beta_two));
          write_cfg(adamu_pkg::CFG_EPSILON,   CDW'(adamu_pkg::CfgReset.epsilon_term));
          write_cfg(adamu_pkg::CFG_BASE_RATE, CDW'(adamu_pkg::CfgReset.base_rate));
        end
        1: begin
          write_cfg(adamu_pkg::CFG_BETA_ONE,  31'd0);
          write_cfg(adamu_pkg::CFG_BETA_TWO,  31'd0);
          write_cfg(adamu_pkg::CFG_EPSILON,   31'h00FF_FFFF);
          write_cfg(adamu_pkg::CFG_BASE_RATE, 31'd0);
        end
        2: begin
          write_cfg(adamu_pkg::CFG_BETA_ONE,  31'h00FF_FFFF);
          write_cfg(adamu_pkg::CFG_BETA_TWO,  31'h00FF_FFFF);
          write_cfg(adamu_pkg::CFG_EPSILON,   31'd1);
          write_cfg(adamu_pkg::CFG_BASE_RATE, 31'h7FFF_FFFF);
        end
        default: begin
          write_cfg(adamu_pkg::CFG_BETA_ONE,  CDW'($urandom));
          write_cfg(adamu_pkg::CFG_BETA_TWO,  CDW'($urandom));
          write_cfg(adamu_pkg::CFG_EPSILON,   CDW'($urandom_range(32'h00FF_FFFF)));
          write_cfg(adamu_pkg::CFG_BASE_RATE, CDW'($urandom));
        end
      endcase
      cfg_valid_i <= 1'b0;
      sent = 0;
      while (sent < ItemsPhase) begin
        // Quiet stretch with no idling on either side.
        quiet = (phase == 1);
        if (phase == 3 && sent >= 30 && !hold_done) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(9) == 0) begin
          // Noise: any index, random pass mark.
          send_item(IW'($urandom), 1'($urandom_range(1)), DW'($urandom), DW'($urandom));
          sent++;
        end else begin
          // Well-formed pass over a small window so moments build up.
          base = IW'($urandom);
          pass_len = $urandom_range(12);
          send_item(base, 1'b1, pick_value(), pick_value());
          sent++;
          for (int k = 0; k < pass_len; k++) begin
            send_item(IW'(base + $urandom_range(7)), 1'b0, pick_value(), pick_value());
            sent++;
          end
        end
      end
      drain();
      quiet = 1'b0;
    end

    $display("ran %0d updates over %0d register settings", items_sent, NumPhases + 2);
    $display("checked %0d results, %0d saturated", sb.checked, sb.sat_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[adam_parameter_update] OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[adam_parameter_update] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/adamu_pkg.sv
rtl/adamu_sqrt.sv
rtl/adamu_div.sv
rtl/adamu_dp.sv
rtl/adamu_ctrl.sv
rtl/adam_parameter_update.sv
tb/adam_parameter_update_test.sv
